// ===== sv/bdm_pkg.sv =====
package bdm_pkg;

    // Frame and sample limits.
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT) + 1;
    localparam int WIDTH_BITS  = COL_BITS + 1;
    localparam int HEIGHT_BITS = ROW_BITS;
    localparam int OUT_Y_BITS  = ROW_BITS - 1;

    // Line store: four earlier rows of one column packed in a word.
    localparam int LINE_ROWS   = 4;
    localparam int LINE_BITS   = LINE_ROWS * SAMPLE_BITS;

    // Port widths.
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 64;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [1:0] METHOD_BILINEAR   = 2'd0;
    localparam logic [1:0] METHOD_COLOR_DIFF = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] smp_t;
    typedef smp_t [4:0] col_t;
    typedef col_t [4:0] win_t;
    typedef smp_t [2:0][2:0] blk_t;
    typedef logic signed [14:0] pos_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_METHOD      = 3'd0,
        REG_GREEN_PHASE = 3'd1,
        REG_RED_PX      = 3'd2,
        REG_RED_PY      = 3'd3,
        REG_BLUE_PX     = 3'd4,
        REG_BLUE_PY     = 3'd5,
        REG_FRAME_W     = 3'd6,
        REG_FRAME_H     = 3'd7
    } reg_idx_t;

    // True when (a, b) lies at least lo from the top-left edges and
    // more than gap-1 inside the bottom-right edges.
    function automatic logic in_core(pos_t a, pos_t b, pos_t w, pos_t h,
                                     pos_t lo, pos_t gap);
        return (a >= lo) && (a < w - gap) && (b >= lo) && (b < h - gap);
    endfunction

    // Green at one site from its four direct neighbors.
    function automatic smp_t green_pick(logic edge_mode, logic keep_raw,
                                        smp_t c, smp_t l, smp_t r,
                                        smp_t u, smp_t d);
        logic [SAMPLE_BITS:0]          sum_h;
        logic [SAMPLE_BITS:0]          sum_v;
        logic [SAMPLE_BITS+1:0]        sum4;
        logic signed [SAMPLE_BITS+1:0] dv;
        logic signed [SAMPLE_BITS+1:0] dh;
        logic [SAMPLE_BITS+1:0]        av;
        logic [SAMPLE_BITS+1:0]        ah;
        smp_t                          res;
        sum_h = {1'b0, l} + {1'b0, r};
        sum_v = {1'b0, u} + {1'b0, d};
        sum4  = {1'b0, sum_h} + {1'b0, sum_v};
        dv = $signed({2'b00, d}) - $signed({2'b00, u});
        dh = $signed({2'b00, r}) - $signed({2'b00, l});
        av = dv[SAMPLE_BITS+1] ? $unsigned(-dv) : $unsigned(dv);
        ah = dh[SAMPLE_BITS+1] ? $unsigned(-dh) : $unsigned(dh);
        if (keep_raw) begin
            res = c;
        end else if (!edge_mode) begin
            res = sum4[SAMPLE_BITS+1:2];
        end else if (av > ah) begin
            res = sum_h[SAMPLE_BITS:1];
        end else begin
            res = sum_v[SAMPLE_BITS:1];
        end
        return res;
    endfunction

    // Raw minus green, sign extended for the difference sum.
    function automatic logic signed [SAMPLE_BITS+3:0] diff_rg(smp_t a, smp_t g);
        return $signed({4'b0000, a}) - $signed({4'b0000, g});
    endfunction

    // Red or blue at the center of a 3x3 block, indexed [x][y].
    function automatic smp_t chroma_pick(logic core, logic colx, logic coly,
                                         logic cdiff, blk_t raw, blk_t grn);
        logic [SAMPLE_BITS+1:0]        bsum;
        logic signed [SAMPLE_BITS+3:0] dsum;
        logic signed [SAMPLE_BITS+3:0] dshift;
        logic signed [SAMPLE_BITS+4:0] v;
        smp_t                          res;
        if (colx) begin
            bsum = {2'b00, raw[1][0]} + {2'b00, raw[1][2]};
            dsum = diff_rg(raw[1][0], grn[1][0]) + diff_rg(raw[1][2], grn[1][2]);
            dshift = dsum >>> 1;
            bsum = bsum >> 1;
        end else if (coly) begin
            bsum = {2'b00, raw[0][1]} + {2'b00, raw[2][1]};
            dsum = diff_rg(raw[0][1], grn[0][1]) + diff_rg(raw[2][1], grn[2][1]);
            dshift = dsum >>> 1;
            bsum = bsum >> 1;
        end else begin
            bsum = {2'b00, raw[0][0]} + {2'b00, raw[2][0]}
                 + {2'b00, raw[0][2]} + {2'b00, raw[2][2]};
            dsum = diff_rg(raw[0][0], grn[0][0]) + diff_rg(raw[2][0], grn[2][0])
                 + diff_rg(raw[0][2], grn[0][2]) + diff_rg(raw[2][2], grn[2][2]);
            dshift = dsum >>> 2;
            bsum = bsum >> 2;
        end
        v = $signed({5'b00000, grn[1][1]}) + {dshift[SAMPLE_BITS+3], dshift};
        if (!core || (colx && coly)) begin
            res = raw[1][1];
        end else if (!cdiff) begin
            res = bsum[SAMPLE_BITS-1:0];
        end else if (v < 0) begin
            res = '0;
        end else if (v > $signed({5'b00000, {SAMPLE_BITS{1'b1}}})) begin
            res = '1;
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/bdm_ram.sv =====
module bdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; data holds without a read.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bayer_demosaic_stream.sv =====
// Channel   Direction  Payload
// s_*       in         tdata: sample[11:0]; tuser: pad
// m_*       out        tdata: red, green, blue, out_x, out_y; tlast: frame_end
// cfg_*     in         write enable, register index, write data
//
// One request per clock while the m_ side is ready; each pixel leaves after the
// request that completes its 5x5 neighborhood (read, window, green, chroma).
// The line store takes at most one read and one write per cycle, at successive columns.
// A stalled m_ side holds only its own register until bubbles in the
// pipeline are used up. Reset clears control, configuration and the window;
// the line store is not cleared.
module bayer_demosaic_stream (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdm_pkg::S_TDATA_BITS-1:0]    s_tdata,  // sample[11:0]
    input  logic                                s_tuser,  // pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // red[11:0], green[23:12], blue[35:24], out_x[46:36], out_y[58:47]
    output logic [bdm_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [bdm_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [bdm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    // Configuration.
    logic [1:0]                          method_reg;
    logic                                green_phase_reg;
    logic                                red_px_reg, red_py_reg;
    logic                                blue_px_reg, blue_py_reg;
    logic [bdm_pkg::WIDTH_BITS-1:0]      width_reg;
    logic [bdm_pkg::HEIGHT_BITS-1:0]     height_reg;
    logic [bdm_pkg::WIDTH_BITS-1:0]      width_clamp;
    logic [bdm_pkg::HEIGHT_BITS-1:0]     height_clamp;

    // Raster position.
    logic [bdm_pkg::COL_BITS-1:0]        cx_reg, cx_next;
    logic [bdm_pkg::ROW_BITS-1:0]        cy_reg, cy_next;

    // Handshake chain.
    logic out_free, s3_free, s2_free, s1_free, accept, s1_move;

    // Position math of the incoming request.
    bdm_pkg::pos_t cx_p, cy_p, w_p, h_p, ox_p, oy_p, cy_n;
    logic          wrapped, emit_s0, last_s0, col_wrap, restart;
    logic [bdm_pkg::WIDTH_BITS-1:0] cx_inc;

    // Stage 1: line store read data is valid.
    logic                           v1_reg, emit1_reg, last1_reg;
    bdm_pkg::smp_t                  smp1_reg;
    logic [bdm_pkg::COL_BITS-1:0]   cx1_reg, ox1_reg;
    logic [bdm_pkg::OUT_Y_BITS-1:0] oy1_reg;
    logic [bdm_pkg::LINE_BITS-1:0]  line_rd;
    bdm_pkg::col_t                  col_in;

    // Stage 2: window.
    logic                           v2_reg, emit2_reg, last2_reg;
    logic [bdm_pkg::COL_BITS-1:0]   ox2_reg;
    logic [bdm_pkg::OUT_Y_BITS-1:0] oy2_reg;
    bdm_pkg::win_t                  win_reg, win_next;
    bdm_pkg::col_t                  pend_reg [2];
    bdm_pkg::blk_t                  raw_s2, grn_s2;
    logic                           core_s2;
    bdm_pkg::pos_t                  ox2_p, oy2_p;

    // Stage 3: greens and raw block.
    logic                           v3_reg, emit3_reg, last3_reg;
    logic [bdm_pkg::COL_BITS-1:0]   ox3_reg;
    logic [bdm_pkg::OUT_Y_BITS-1:0] oy3_reg;
    bdm_pkg::blk_t                  raw3_reg, grn3_reg;
    logic                           core3_reg;
    logic                           rcx3_reg, rcy3_reg, bcx3_reg, bcy3_reg;
    bdm_pkg::smp_t                  red_s3, blue_s3;

    // Output register.
    logic                           m_valid_reg, m_last_reg;
    bdm_pkg::smp_t                  m_red_reg, m_green_reg, m_blue_reg;
    logic [bdm_pkg::COL_BITS-1:0]   m_x_reg;
    logic [bdm_pkg::OUT_Y_BITS-1:0] m_y_reg;

    // Frame size is clamped once, at the write.
    always_comb begin
        width_clamp = cfg_wdata[bdm_pkg::WIDTH_BITS-1:0];
        if (width_clamp < bdm_pkg::WIDTH_BITS'(bdm_pkg::MIN_SIZE)) begin
            width_clamp = bdm_pkg::WIDTH_BITS'(bdm_pkg::MIN_SIZE);
        end else if (width_clamp > bdm_pkg::WIDTH_BITS'(bdm_pkg::MAX_WIDTH)) begin
            width_clamp = bdm_pkg::WIDTH_BITS'(bdm_pkg::MAX_WIDTH);
        end
        height_clamp = cfg_wdata[bdm_pkg::HEIGHT_BITS-1:0];
        if (height_clamp < bdm_pkg::HEIGHT_BITS'(bdm_pkg::MIN_SIZE)) begin
            height_clamp = bdm_pkg::HEIGHT_BITS'(bdm_pkg::MIN_SIZE);
        end else if (height_clamp > bdm_pkg::HEIGHT_BITS'(bdm_pkg::MAX_HEIGHT)) begin
            height_clamp = bdm_pkg::HEIGHT_BITS'(bdm_pkg::MAX_HEIGHT);
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg      <= bdm_pkg::METHOD_COLOR_DIFF;
            green_phase_reg <= 1'b0;
            red_px_reg      <= 1'b1;
            red_py_reg      <= 1'b1;
            blue_px_reg     <= 1'b0;
            blue_py_reg     <= 1'b0;
            width_reg       <= bdm_pkg::WIDTH_BITS'(bdm_pkg::MAX_WIDTH);
            height_reg      <= bdm_pkg::HEIGHT_BITS'(1536);
        end else if (cfg_we) begin
            unique case (bdm_pkg::reg_idx_t'(cfg_addr))
                bdm_pkg::REG_METHOD:      method_reg      <= cfg_wdata[1:0];
                bdm_pkg::REG_GREEN_PHASE: green_phase_reg <= cfg_wdata[0];
                bdm_pkg::REG_RED_PX:      red_px_reg      <= cfg_wdata[0];
                bdm_pkg::REG_RED_PY:      red_py_reg      <= cfg_wdata[0];
                bdm_pkg::REG_BLUE_PX:     blue_px_reg     <= cfg_wdata[0];
                bdm_pkg::REG_BLUE_PY:     blue_py_reg     <= cfg_wdata[0];
                bdm_pkg::REG_FRAME_W:     width_reg       <= width_clamp;
                bdm_pkg::REG_FRAME_H:     height_reg      <= height_clamp;
                default: ;
            endcase
        end
    end

    // Ready chain: a stage takes new work when it is empty or moves on.
    assign out_free = !m_valid_reg || m_tready;
    assign s3_free  = !v3_reg || !emit3_reg || out_free;
    assign s2_free  = !v2_reg || s3_free;
    assign s1_free  = !v1_reg || s2_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s1_free;
    assign s1_move  = v1_reg && s2_free;

    // Output position of the incoming request and the next raster position.
    always_comb begin
        cx_p = bdm_pkg::pos_t'(cx_reg);
        cy_p = bdm_pkg::pos_t'(cy_reg);
        w_p  = bdm_pkg::pos_t'(width_reg);
        h_p  = bdm_pkg::pos_t'(height_reg);
        wrapped = cx_reg < bdm_pkg::COL_BITS'(2);
        ox_p = wrapped ? cx_p + w_p - bdm_pkg::pos_t'(2) : cx_p - bdm_pkg::pos_t'(2);
        oy_p = wrapped ? cy_p - bdm_pkg::pos_t'(3) : cy_p - bdm_pkg::pos_t'(2);
        emit_s0 = (oy_p >= 0) && (oy_p < h_p) && (ox_p >= 0) && (ox_p < w_p);
        last_s0 = emit_s0 && (ox_p == w_p - bdm_pkg::pos_t'(1))
                          && (oy_p == h_p - bdm_pkg::pos_t'(1));
        cx_inc   = {1'b0, cx_reg} + bdm_pkg::WIDTH_BITS'(1);
        col_wrap = cx_inc >= width_reg;
        cy_n     = col_wrap ? cy_p + bdm_pkg::pos_t'(1) : cy_p;
        restart  = last_s0 || (cy_n > h_p + bdm_pkg::pos_t'(2));
        cx_next  = (restart || col_wrap) ? '0 : cx_inc[bdm_pkg::COL_BITS-1:0];
        cy_next  = restart ? '0 : cy_n[bdm_pkg::ROW_BITS-1:0];
    end

    // Raster counters and stage 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            v1_reg <= 1'b0;
        end else begin
            if (accept) begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
            end
            if (s1_free) begin
                v1_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            smp1_reg  <= s_tuser ? '0 : s_tdata[bdm_pkg::SAMPLE_BITS-1:0];
            cx1_reg   <= cx_reg;
            emit1_reg <= emit_s0;
            last1_reg <= last_s0;
            ox1_reg   <= ox_p[bdm_pkg::COL_BITS-1:0];
            oy1_reg   <= oy_p[bdm_pkg::OUT_Y_BITS-1:0];
        end
    end

    // Line store: four earlier rows per column, shifted up on write-back.
    bdm_ram #(
        .WIDTH (bdm_pkg::LINE_BITS),
        .DEPTH (bdm_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (s1_move),
        .wr_addr (cx1_reg),
        .wr_data ({smp1_reg, line_rd[bdm_pkg::LINE_BITS-1:bdm_pkg::SAMPLE_BITS]}),
        .rd_en   (accept),
        .rd_addr (cx_reg),
        .rd_data (line_rd)
    );

    // New column of the window, oldest row first.
    always_comb begin
        for (int k = 0; k < bdm_pkg::LINE_ROWS; k++) begin
            col_in[k] = line_rd[k*bdm_pkg::SAMPLE_BITS +: bdm_pkg::SAMPLE_BITS];
        end
        col_in[4] = smp1_reg;
    end

    // Window shift. The first two columns of a row are parked while the
    // previous row's last pixels drain, and restored at column two.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            win_next[c] = win_reg[c+1];
        end
        win_next[4] = col_in;
        if (cx1_reg == bdm_pkg::COL_BITS'(2)) begin
            win_next[2] = pend_reg[0];
            win_next[3] = pend_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg      <= 1'b0;
            win_reg     <= '0;
            pend_reg[0] <= '0;
            pend_reg[1] <= '0;
        end else begin
            if (s2_free) begin
                v2_reg <= v1_reg;
            end
            if (s1_move) begin
                win_reg <= win_next;
                if (cx1_reg < bdm_pkg::COL_BITS'(2)) begin
                    pend_reg[cx1_reg[0]] <= col_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            emit2_reg <= emit1_reg;
            last2_reg <= last1_reg;
            ox2_reg   <= ox1_reg;
            oy2_reg   <= oy1_reg;
        end
    end

    // Greens of the 3x3 around the pixel; the center follows the method.
    always_comb begin
        bdm_pkg::pos_t a, b;
        logic          edge_mode, core, gsite;
        ox2_p = bdm_pkg::pos_t'(ox2_reg);
        oy2_p = bdm_pkg::pos_t'(oy2_reg);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a = ox2_p + bdm_pkg::pos_t'(i) - bdm_pkg::pos_t'(1);
                b = oy2_p + bdm_pkg::pos_t'(j) - bdm_pkg::pos_t'(1);
                edge_mode = (i == 1 && j == 1) ?
                            (method_reg != bdm_pkg::METHOD_BILINEAR) : 1'b1;
                core = edge_mode ?
                    bdm_pkg::in_core(a, b, w_p, h_p, bdm_pkg::pos_t'(1), bdm_pkg::pos_t'(1)) :
                    bdm_pkg::in_core(a, b, w_p, h_p, bdm_pkg::pos_t'(2), bdm_pkg::pos_t'(1));
                gsite = !(a[0] ^ b[0] ^ green_phase_reg);
                raw_s2[i][j] = win_reg[i+1][j+1];
                grn_s2[i][j] = bdm_pkg::green_pick(edge_mode, !core || gsite,
                                                   win_reg[i+1][j+1],
                                                   win_reg[i][j+1],
                                                   win_reg[i+2][j+1],
                                                   win_reg[i+1][j],
                                                   win_reg[i+1][j+2]);
            end
        end
        core_s2 = bdm_pkg::in_core(ox2_p, oy2_p, w_p, h_p,
                                   bdm_pkg::pos_t'(2), bdm_pkg::pos_t'(2));
    end

    // Stage 3.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (s3_free) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_free) begin
            emit3_reg <= emit2_reg;
            last3_reg <= last2_reg;
            ox3_reg   <= ox2_reg;
            oy3_reg   <= oy2_reg;
            raw3_reg  <= raw_s2;
            grn3_reg  <= grn_s2;
            core3_reg <= core_s2;
            rcx3_reg  <= !(ox2_reg[0] ^ red_px_reg);
            rcy3_reg  <= !(oy2_reg[0] ^ red_py_reg);
            bcx3_reg  <= !(ox2_reg[0] ^ blue_px_reg);
            bcy3_reg  <= !(oy2_reg[0] ^ blue_py_reg);
        end
    end

    // Red and blue from the registered blocks.
    always_comb begin
        red_s3  = bdm_pkg::chroma_pick(core3_reg, rcx3_reg, rcy3_reg,
                                       method_reg >= bdm_pkg::METHOD_COLOR_DIFF,
                                       raw3_reg, grn3_reg);
        blue_s3 = bdm_pkg::chroma_pick(core3_reg, bcx3_reg, bcy3_reg,
                                       method_reg >= bdm_pkg::METHOD_COLOR_DIFF,
                                       raw3_reg, grn3_reg);
    end

    // Output register; positions without a pixel are dropped here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= v3_reg && emit3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_red_reg   <= red_s3;
            m_green_reg <= grn3_reg[1][1];
            m_blue_reg  <= blue_s3;
            m_x_reg     <= ox3_reg;
            m_y_reg     <= oy3_reg;
            m_last_reg  <= last3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b00000, m_y_reg, m_x_reg, m_blue_reg, m_green_reg, m_red_reg};

endmodule
